[src/temporal_median_scan_filter_macros.svh]
// Assertion macros for the temporal median scan filter.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef TEMPORAL_MEDIAN_SCAN_FILTER_MACROS_SVH
`define TEMPORAL_MEDIAN_SCAN_FILTER_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define TMSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// A condition that must be followed by another one in the next cycle.
`define TMSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TMSF_ASSERT(label, prop, msg)
`define TMSF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[src/tmsf_pkg.sv]
// Shared types and constants of the temporal median scan filter.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package tmsf_pkg;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 11;
  localparam int DEPTH_BITS     = 3;
  localparam int LENGTH_BITS    = 11;

  localparam logic [CFG_INDEX_BITS-1:0] REG_HISTORY_DEPTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCAN_LENGTH   = 2'd1;

  localparam logic [DEPTH_BITS-1:0]  RESET_HISTORY_DEPTH = 3'd4;
  localparam logic [LENGTH_BITS-1:0] RESET_SCAN_LENGTH   = 11'd1024;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;       // input transfer: store sample, seed the sorted list
    logic issue_read;  // read one earlier scan value from the history memory
    logic insert;      // insert the value just read into the sorted list
    logic finish;      // load the result register and advance the scan state
  } tmsf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_history; // at least one earlier complete scan is held
    logic last_read;   // the value being inserted is the last earlier one
    logic out_free;    // the result register can take a new result
  } tmsf_status_t;

endpackage

`default_nettype wire

[src/tmsf_controller.sv]
// Sequencing state machine of the temporal median scan filter.
// Depends on tmsf_pkg for the command and status types.
`default_nettype none

module tmsf_controller
  import tmsf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire tmsf_status_t status,
  output tmsf_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_INSERT = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = status.has_history ? ST_READ : ST_FINISH;
        end
      end
      ST_READ: begin
        cmd.issue_read = 1'b1;
        state_next     = ST_INSERT;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = status.last_read ? ST_FINISH : ST_READ;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[src/tmsf_datapath.sv]
// Datapath of the temporal median scan filter: configuration, scan ring state,
// history memory, sorted value list and result register. Depends on tmsf_pkg.
`default_nettype none

module tmsf_datapath
  import tmsf_pkg::*;
#(
  parameter int MAX_SCANS   = 8,
  parameter int MAX_BEAMS   = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int BEAM_BITS   = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic [SAMPLE_BITS-1:0]    range_sample,
  input  wire tmsf_cmd_t                 cmd,
  output tmsf_status_t                   status,
  input  wire logic                      out_stall,
  output logic                           out_valid,
  output logic [SAMPLE_BITS:0]           median_range,
  output logic [BEAM_BITS-1:0]           beam_index,
  output logic                           last_of_scan
);

  localparam int SLOT_BITS = (MAX_SCANS > 1) ? $clog2(MAX_SCANS) : 1;
  localparam int CNT_BITS  = $clog2(MAX_SCANS + 1);
  localparam int LEN_BITS  = $clog2(MAX_BEAMS + 1);
  localparam int LW        = LEN_BITS + 1;
  localparam int MEM_DEPTH = MAX_SCANS * (2 ** BEAM_BITS);
  localparam int ADDR_BITS = SLOT_BITS + BEAM_BITS;

  logic [DEPTH_BITS-1:0]  history_depth;
  logic [LENGTH_BITS-1:0] scan_length;
  logic [SLOT_BITS-1:0]   eff_depth;
  logic [LEN_BITS-1:0]    eff_len;

  logic [BEAM_BITS-1:0]   beam_position;
  logic [SLOT_BITS-1:0]   current_slot;
  logic [SLOT_BITS-1:0]   scans_held;

  logic [SAMPLE_BITS-1:0] history_mem [MEM_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SLOT_BITS-1:0]   rd_slot;
  logic [SLOT_BITS-1:0]   left;

  logic [SAMPLE_BITS-1:0] vals [MAX_SCANS];
  logic [SAMPLE_BITS-1:0] ins  [MAX_SCANS];
  logic [MAX_SCANS-1:0]   gt;
  logic [CNT_BITS-1:0]    k;

  logic [CNT_BITS-1:0]    mid;
  logic [SLOT_BITS-1:0]   idx_hi;
  logic [SLOT_BITS-1:0]   idx_lo;
  logic [SAMPLE_BITS:0]   median;
  logic [LW-1:0]          pos_inc;
  logic                   last;
  logic                   cfg_hit;

  // Effective depth and scan length after clamping to the storage.
  always_comb begin
    if (32'(history_depth) > MAX_SCANS - 1) begin
      eff_depth = SLOT_BITS'(MAX_SCANS - 1);
    end else begin
      eff_depth = SLOT_BITS'(history_depth);
    end
    if (scan_length == '0) begin
      eff_len = LEN_BITS'(1);
    end else if (32'(scan_length) > MAX_BEAMS) begin
      eff_len = LEN_BITS'(MAX_BEAMS);
    end else begin
      eff_len = LEN_BITS'(scan_length);
    end
  end

  assign cfg_hit = cfg_write &&
                   ((cfg_index == REG_HISTORY_DEPTH) || (cfg_index == REG_SCAN_LENGTH));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      history_depth <= RESET_HISTORY_DEPTH;
      scan_length   <= RESET_SCAN_LENGTH;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HISTORY_DEPTH: history_depth <= cfg_data[DEPTH_BITS-1:0];
        REG_SCAN_LENGTH:   scan_length   <= cfg_data[LENGTH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // End of scan detection and ring advance.
  assign pos_inc = LW'(beam_position) + LW'(1);
  assign last    = (pos_inc >= LW'(eff_len));

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      beam_position <= '0;
      current_slot  <= '0;
      scans_held    <= '0;
    end else if (cmd.finish) begin
      if (last) begin
        beam_position <= '0;
        current_slot  <= (current_slot == eff_depth) ? '0 : current_slot + 1'b1;
        if (scans_held < eff_depth) begin
          scans_held <= scans_held + 1'b1;
        end
      end else begin
        beam_position <= BEAM_BITS'(pos_inc);
      end
    end
  end

  // History memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      history_mem[ADDR_BITS'({current_slot, beam_position})] <= range_sample;
    end
    if (cmd.issue_read) begin
      rd_data <= history_mem[ADDR_BITS'({rd_slot, beam_position})];
    end
  end

  // Insertion of the value just read into the ascending list.
  always_comb begin
    for (int i = 0; i < MAX_SCANS; i++) begin
      gt[i] = (CNT_BITS'(i) < k) && (vals[i] > rd_data);
    end
    ins[0] = ((k != '0) && !gt[0]) ? vals[0] : rd_data;
    for (int i = 1; i < MAX_SCANS; i++) begin
      if ((CNT_BITS'(i) < k) && !gt[i]) begin
        ins[i] = vals[i];
      end else if (!gt[i-1]) begin
        ins[i] = rd_data;
      end else begin
        ins[i] = vals[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      vals[0] <= range_sample;
      k       <= CNT_BITS'(1);
      left    <= scans_held;
      rd_slot <= (current_slot == '0) ? eff_depth : current_slot - 1'b1;
    end else if (cmd.insert) begin
      for (int i = 0; i < MAX_SCANS; i++) begin
        vals[i] <= ins[i];
      end
      k       <= k + 1'b1;
      left    <= left - 1'b1;
      rd_slot <= (rd_slot == '0) ? eff_depth : rd_slot - 1'b1;
    end
  end

  // Median in half units: twice the middle value, or the sum of the two middle ones.
  assign mid    = k >> 1;
  assign idx_hi = mid[SLOT_BITS-1:0];
  assign idx_lo = idx_hi - 1'b1;

  always_comb begin
    if (k[0]) begin
      median = {vals[idx_hi], 1'b0};
    end else begin
      median = {1'b0, vals[idx_lo]} + {1'b0, vals[idx_hi]};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      median_range <= median;
      beam_index   <= beam_position;
      last_of_scan <= last;
    end
  end

  assign status.has_history = (scans_held != '0);
  assign status.last_read   = (left == SLOT_BITS'(1));
  assign status.out_free    = !out_valid || !out_stall;

endmodule

`default_nettype wire

[src/temporal_median_scan_filter.sv]
// Top level of the temporal median scan filter: controller and datapath.
// Depends on tmsf_pkg, tmsf_controller, tmsf_datapath and the assertion macros.
//
// Usage:
// Range samples enter one beam at a time on the input channel (in_valid,
// in_stall, range_sample); a transfer happens at a clock edge with in_valid
// high and in_stall low. Each sample yields exactly one result on the output
// channel (out_valid, out_stall, median_range, beam_index, last_of_scan):
// the median of the samples at that beam from the current scan and up to
// history_depth earlier complete scans, given in half units of the input.
// At most min(history_depth, MAX_SCANS-1) earlier scans are held. The history
// memory has a single read port: every earlier value is read in turn and
// inserted into the sorted list in the next cycle. A finished result waits in
// the output register; the next sample is taken while it waits, but a second
// result is held back until the receiver releases out_stall. Reset (rst,
// synchronous) empties the history, restores history_depth to 4 and
// scan_length to 1024. The history memory needs no clearing pass. A write to
// either register also empties the history.
`default_nettype none
`include "temporal_median_scan_filter_macros.svh"

module temporal_median_scan_filter
  import tmsf_pkg::*;
#(
  parameter int MAX_SCANS   = 8,
  parameter int MAX_BEAMS   = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int BEAM_BITS   = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [SAMPLE_BITS-1:0]    range_sample,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [SAMPLE_BITS:0]           median_range,
  output logic [BEAM_BITS-1:0]           beam_index,
  output logic                           last_of_scan
);

  tmsf_cmd_t    cmd;
  tmsf_status_t status;

  // The controller walks each item through store, read/insert per earlier
  // scan, and finish; it holds in_stall high for the whole walk.
  tmsf_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath owns the registers, the scan ring, the history memory and
  // the sorted list from which the median is taken.
  tmsf_datapath #(
    .MAX_SCANS   (MAX_SCANS),
    .MAX_BEAMS   (MAX_BEAMS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .BEAM_BITS   (BEAM_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .range_sample (range_sample),
    .cmd          (cmd),
    .status       (status),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .median_range (median_range),
    .beam_index   (beam_index),
    .last_of_scan (last_of_scan)
  );

  // An accepted sample keeps the input stalled while it is worked on.
  `TMSF_ASSERT_NEXT(a_busy_after_start, cmd.start, in_stall, "input not stalled after transfer")
  // Every memory read is followed by the insertion of its data.
  `TMSF_ASSERT_NEXT(a_read_then_insert, cmd.issue_read, cmd.insert, "read without insert")
  // A result is loaded only when the result register can take it.
  `TMSF_ASSERT(a_finish_when_free, !cmd.finish || status.out_free, "result overwritten")

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the temporal median scan filter.
// Depends on tmsf_pkg and the temporal_median_scan_filter top level only.
`timescale 1ns / 100ps

module testbench;
  import tmsf_pkg::*;

  localparam int SAMPLE_W     = 16;
  localparam int BEAM_W       = 10;
  localparam int SCAN_SLOTS   = 8;
  localparam int BEAMS_MAX    = 1024;
  localparam int RANDOM_ITEMS = 560;
  localparam int LONG_ITEMS   = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 2 * (SCAN_SLOTS - 1) + 8;
  localparam int CYCLE_LIMIT  = 2000000;

  // Register indexes that the block does not implement.
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_3 = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W:0]   median;
    logic [BEAM_W-1:0]   beam;
    logic                last;
  } median_result_t;

  // Clock, reset and every block input start at known values.
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [SAMPLE_W-1:0]       range_sample = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [SAMPLE_W:0]         median_range;
  logic [BEAM_W-1:0]         beam_index;
  logic                      last_of_scan;

  temporal_median_scan_filter u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .range_sample (range_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .median_range (median_range),
    .beam_index   (beam_index),
    .last_of_scan (last_of_scan)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor state: our own copy of the scan ring and the two registers.
  // The ring is only ever read at slots that hold a finished earlier scan
  // or the sample just written, so it needs no initial value.
  // ---------------------------------------------------------------------
  logic [SAMPLE_W-1:0] scan_ring [0:SCAN_SLOTS-1][0:BEAMS_MAX-1];
  logic [2:0]          depth_reg  = RESET_HISTORY_DEPTH;
  logic [10:0]         length_reg = RESET_SCAN_LENGTH;
  int unsigned         next_beam  = 0;
  int unsigned         write_slot = 0;
  int unsigned         scans_kept = 0;

  median_result_t expected_medians [$];
  logic [SAMPLE_W-1:0] pending_samples [$];

  // Bookkeeping shared by the processes below.
  bit          offering    = 1'b0;
  bit          in_accepted = 1'b0;
  bit          calm        = 1'b0;
  bit          hold_request = 1'b0;
  int          mismatches  = 0;
  int          medians_checked = 0;
  int          samples_sent = 0;
  int          register_writes = 0;
  int          phases = 0;
  int unsigned cycle_count = 0;

  // Append one sample to the end of the pending list.
  task automatic queue_sample(input logic [SAMPLE_W-1:0] sample);
    pending_samples.insert(pending_samples.size(), sample);
  endtask

  // Append one expectation to the end of the expected list.
  task automatic queue_expected(input median_result_t res);
    expected_medians.insert(expected_medians.size(), res);
  endtask

  // A scan length of zero behaves as one beam, anything above the
  // capacity behaves as the full capacity.
  function automatic int unsigned effective_length(input logic [10:0] raw);
    if (raw == 0) return 1;
    if (raw > BEAMS_MAX) return BEAMS_MAX;
    return raw;
  endfunction

  // Mostly short idle stretches, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Any write to a real register clears the scan history; the unused
  // indexes leave everything as it was.
  task automatic apply_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    if (idx == REG_HISTORY_DEPTH) begin
      depth_reg = data[2:0];
      next_beam = 0;
      write_slot = 0;
      scans_kept = 0;
    end else if (idx == REG_SCAN_LENGTH) begin
      length_reg = data[10:0];
      next_beam = 0;
      write_slot = 0;
      scans_kept = 0;
    end
  endtask

  // Store one sample, gather the same beam from the current scan and the
  // earlier scans held, and work out their median in half units.
  task automatic predict_median(input logic [SAMPLE_W-1:0] sample,
                                output median_result_t res);
    int unsigned ring, len, pos, slot, n, k, i, s;
    logic [SAMPLE_W-1:0] vals [0:SCAN_SLOTS-1];
    logic [SAMPLE_W-1:0] v;
    ring = int'(depth_reg) + 1;
    len  = effective_length(length_reg);
    pos  = next_beam;
    slot = write_slot;
    if (pos >= len) pos = 0;
    if (slot >= ring) slot = 0;
    if (scans_kept > depth_reg) scans_kept = depth_reg;
    scan_ring[slot][pos] = sample;
    n = scans_kept + 1;
    for (k = 0; k < n; k++) begin
      s = (slot + ring - k) % ring;
      v = scan_ring[s][pos];
      i = k;
      while (i > 0 && vals[i-1] > v) begin
        vals[i] = vals[i-1];
        i--;
      end
      vals[i] = v;
    end
    if (n % 2 == 0)
      res.median = {1'b0, vals[n/2-1]} + {1'b0, vals[n/2]};
    else
      res.median = {vals[n/2], 1'b0};
    res.beam = pos[BEAM_W-1:0];
    res.last = (pos + 1 >= len);
    if (res.last) begin
      next_beam = 0;
      write_slot = (slot + 1) % ring;
      if (scans_kept < depth_reg) scans_kept++;
    end else begin
      next_beam = pos + 1;
      write_slot = slot;
    end
  endtask

  // ---------------------------------------------------------------------
  // Input driver: offers the pending samples one at a time at the falling
  // edge. A sample stays on the port until its transfer has been seen at a
  // rising edge; in_valid is only ever assigned once per falling edge, so
  // back-to-back samples keep valid high without a glitch.
  // ---------------------------------------------------------------------
  int unsigned         gap_left = 0;
  logic [SAMPLE_W-1:0] offered_sample = '0;

  always @(negedge clk) begin
    if (!rst) begin
      if (in_accepted) begin
        offering = 1'b0;
        in_accepted = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_samples.size() != 0) begin
          offered_sample = pending_samples.pop_front();
          offering = 1'b1;
          gap_left = calm ? 0 : pick_gap();
        end
      end
      in_valid <= offering;
      // While nothing is offered the data lines carry noise.
      range_sample <= offering ? offered_sample : SAMPLE_W'($urandom);
    end
  end

  // Input monitor: every input transfer feeds the predictor, and its
  // expected result joins the back of the queue.
  always @(posedge clk) begin
    median_result_t res;
    if (!rst && in_valid && in_stall === 1'b0) begin
      predict_median(range_sample, res);
      queue_expected(res);
      samples_sent++;
      in_accepted = 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Output stall driver. Random stall stretches, none in calm phases, and
  // on request one long hold-off counted here so that the block fills up
  // and pushes back on its input while the sender keeps offering.
  // ---------------------------------------------------------------------
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    bit stall_next;
    if (!rst) begin
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (calm) begin
        stall_left = 0;
        stall_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  // Output monitor: each output transfer is checked against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    median_result_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      medians_checked++;
      if (expected_medians.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: median %0d beam %0d last %0d",
                   median_range, beam_index, last_of_scan);
        mismatches++;
      end else begin
        want = expected_medians.pop_front();
        if (median_range !== want.median || beam_index !== want.beam ||
            last_of_scan !== want.last) begin
          if (mismatches < 10)
            $display("mismatch: expected median %0d beam %0d last %0d, got %0d %0d %0d",
                     want.median, want.beam, want.last,
                     median_range, beam_index, last_of_scan);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped by the watchdog after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers used by the sequence below.
  // ---------------------------------------------------------------------

  // Registers are written at a falling edge and take effect at the next
  // rising edge; the predictor follows at the same moment, while idle.
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    apply_register(idx, data);
    register_writes++;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait until every sample went in and every result came out. Each
  // sample yields one result, so a short pause after that is enough.
  task automatic wait_idle();
    while (pending_samples.size() != 0 || offering || expected_medians.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Queue samples shaped like real scans: each beam keeps a base range with
  // a little jitter, broken up by dropouts, saturated returns and noise.
  task automatic queue_scans(input int unsigned count, input int unsigned len);
    logic [SAMPLE_W-1:0] base [0:BEAMS_MAX-1];
    int unsigned b, r, j;
    for (b = 0; b < len; b++) base[b] = SAMPLE_W'($urandom);
    for (j = 0; j < count; j++) begin
      r = $urandom_range(0, 99);
      b = j % len;
      if (r < 8)
        queue_sample('0);
      else if (r < 15)
        queue_sample('1);
      else if (r < 35)
        queue_sample(SAMPLE_W'($urandom));
      else
        queue_sample(base[b] + SAMPLE_W'($urandom_range(0, 31)));
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned random_sent;
    int unsigned depth_pick, len_eff, count, r, which;
    logic [CFG_DATA_BITS-1:0] length_data;
    random_sent = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: depth four, full-length scans. Only the current
    // scan exists, so each median is just twice the sample.
    calm = 1'b1;
    queue_sample(16'h0000);
    queue_sample(16'hFFFF);
    queue_sample(16'hA5A5);
    wait_idle();

    // Writes to unused indexes change nothing, not even the history.
    write_register(REG_UNUSED_2, '1);
    write_register(REG_UNUSED_3, 11'h2AA);

    // One-beam scans against a single earlier scan: every result past the
    // first is a sum of two, up to the largest median there is.
    write_register(REG_HISTORY_DEPTH, 11'd1);
    write_register(REG_SCAN_LENGTH, 11'd1);
    queue_sample(16'h0000);
    queue_sample(16'hFFFF);
    queue_sample(16'hFFFF);
    queue_sample(16'h0001);
    wait_idle();

    // A scan length of zero behaves as one beam; the deepest history
    // grows over these samples, with ties and odd and even counts.
    calm = 1'b0;
    write_register(REG_SCAN_LENGTH, 11'd0);
    write_register(REG_HISTORY_DEPTH, 11'd7);
    queue_sample(16'd500);
    queue_sample(16'd100);
    queue_sample(16'd500);
    queue_sample(16'hFFFF);
    queue_sample(16'd0);
    queue_sample(16'd100);
    wait_idle();

    // Only the low three bits of the depth write count. Two-beam scans,
    // then an unused-index write in the middle keeps the history intact.
    write_register(REG_HISTORY_DEPTH, 11'h7FB);
    write_register(REG_SCAN_LENGTH, 11'd2);
    queue_sample(16'd10);
    queue_sample(16'd20);
    queue_sample(16'd30);
    queue_sample(16'd5);
    queue_sample(16'd30);
    queue_sample(16'd40);
    wait_idle();
    write_register(REG_UNUSED_3, 11'h555);
    queue_sample(16'd1);
    queue_sample(16'hFFFE);
    queue_sample(16'd20);
    queue_sample(16'd20);
    wait_idle();

    // One partial scan at the largest scan length, reached through an
    // oversized write.
    write_register(REG_HISTORY_DEPTH, 11'd1);
    write_register(REG_SCAN_LENGTH, 11'h7FF);
    queue_scans(LONG_ITEMS, BEAMS_MAX);
    wait_idle();

    // Random phases: new settings each time, mostly short scans fed as
    // whole scans, now and then a broken-off partial scan.
    while (random_sent < RANDOM_ITEMS) begin
      phases++;
      calm = (phases % 4 == 0);

      r = $urandom_range(0, 99);
      if (r < 20) depth_pick = 0;
      else if (r < 40) depth_pick = 7;
      else depth_pick = $urandom_range(0, 7);

      r = $urandom_range(0, 99);
      if (r < 70) length_data = 11'($urandom_range(1, 8));
      else if (r < 88) length_data = 11'($urandom_range(9, 40));
      else if (r < 95) length_data = 11'd0;
      else length_data = 11'($urandom_range(BEAMS_MAX + 1, 2047));

      // Both registers in either order, or only one of them.
      which = $urandom_range(0, 3);
      if (which == 0) begin
        write_register(REG_HISTORY_DEPTH,
                       {8'($urandom), 3'(depth_pick)});
        write_register(REG_SCAN_LENGTH, length_data);
      end else if (which == 1) begin
        write_register(REG_SCAN_LENGTH, length_data);
        write_register(REG_HISTORY_DEPTH,
                       {8'($urandom), 3'(depth_pick)});
      end else if (which == 2) begin
        write_register(REG_HISTORY_DEPTH,
                       {8'($urandom), 3'(depth_pick)});
      end else begin
        write_register(REG_SCAN_LENGTH, length_data);
      end
      if ($urandom_range(0, 7) == 0)
        write_register($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                       CFG_DATA_BITS'($urandom));

      len_eff = effective_length(length_reg);
      if (len_eff > 40) begin
        count = $urandom_range(10, 30);
      end else begin
        count = len_eff * $urandom_range(1, depth_reg + 3);
        if ($urandom_range(0, 3) == 0) count += $urandom_range(0, len_eff - 1);
        if (count > 150) count = 150;
      end

      // The first random phase runs under the long receiver hold-off.
      if (phases == 1) begin
        calm = 1'b0;
        if (count < 60) count = 60;
        hold_request = 1'b1;
      end

      queue_scans(count, len_eff);
      random_sent += count;
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d samples and %0d checked medians over %0d random phases",
             samples_sent, medians_checked, phases);
    $display("with %0d register writes; %0d mismatches found", register_writes,
             mismatches);
    if (mismatches == 0 && expected_medians.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/tmsf_pkg.sv
src/tmsf_controller.sv
src/tmsf_datapath.sv
src/temporal_median_scan_filter.sv
test/testbench.sv
